FILE: src/otse_pkg.sv
// Shared types, codes and fixed constants of the edit engine.
package otse_pkg;

    // Revision counter width, fixed by the field width.
    localparam int REV_W = 16;
    localparam logic [REV_W-1:0] REV_MAX = 16'hFFFF;

    // Operation codes.
    localparam logic OP_EDIT = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Edit kinds.
    localparam logic KIND_INS = 1'b0;
    localparam logic KIND_DEL = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_APPLIED = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_BADREV  = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    typedef struct packed {
        logic        operation;
        logic        edit_kind;
        logic [15:0] base_revision;
        logic [12:0] position;
        logic [7:0]  character;
        logic [7:0]  client;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        result_kind;
        logic [15:0] result_revision;
        logic [12:0] result_position;
        logic [7:0]  result_character;
        logic [7:0]  result_client;
        logic [12:0] doc_length;
    } t_out_item;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_HRD  = 8'b0000_0010,
        S_HEV  = 8'b0000_0100,
        S_CHK  = 8'b0000_1000,
        S_MRD  = 8'b0001_0000,
        S_MWR  = 8'b0010_0000,
        S_DRD  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

endpackage

FILE: src/otse_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module otse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: src/ot_server_edit_engine_core.sv
// Top level of the operational transformation edit engine.
//
//  channel | direction | signals                  | payload
//  --------+-----------+--------------------------+-----------
//  input   | in        | i_valid / o_ready        | i_item
//  result  | out       | o_valid / i_ready        | o_item
//
// Path back to idle: an applied edit walks each missed history entry (history RAM read,
// then the transform compare), checks the range, then moves each document character of
// the tail shift, read then written, through the single document RAM port pair.
// A dropped edit stops at the entry that drops it, a range reject after the walk and the
// range check, a revision reject directly; a read reads the document RAM if in range.
// One item is in work at a time; o_ready is high only while the sequencer is idle. The
// result sits in an output register and the next item is taken while it waits; the
// finishing state stalls while that register still holds an untaken result. Reset
// empties the document and the history; both stores need no clearing pass.
module ot_server_edit_engine_core import otse_pkg::*; #(
    parameter int DOC_CHARS     = 4096,
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int AW  = $clog2(DOC_CHARS);
    localparam int LW  = $clog2(DOC_CHARS + 1);
    localparam int HAW = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int PW  = $clog2(8192 + HISTORY_DEPTH + DOC_CHARS);
    localparam int HEW = LW + 10;
    localparam int XW  = REV_W + 2;

    t_state          r_state, n_state;
    t_in_item        r_in, n_in;
    t_out_item       r_res, n_res;
    t_out_item       n_oitem;
    logic            n_ovalid;
    logic [PW-1:0]   r_p, n_p;
    logic [PW-1:0]   r_j, n_j;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [HAW-1:0]  r_idx, n_idx;
    logic [HAW-1:0]  r_wptr, n_wptr;
    logic [REV_W-1:0] r_rev, n_rev;
    logic [LW-1:0]   r_len, n_len;

    // RAM ports.
    logic            d_we;
    logic [AW-1:0]   d_waddr, d_raddr;
    logic [7:0]      d_wdata, d_rdata;
    logic            h_we;
    logic [HAW-1:0]  h_raddr;
    logic [HEW-1:0]  h_wdata, h_rdata;

    // Decoded history entry.
    logic            e_kind, e_drop;
    logic [LW-1:0]   e_pos;
    logic [7:0]      e_client;
    logic [PW-1:0]   e_pos_w;
    logic [PW-1:0]   sh_p;
    logic            sh_drop;

    // Helpers for the accept decision and addressing.
    logic [REV_W-1:0] diff;
    logic [XW-1:0]   idx_t;
    logic [PW-1:0]   pos_w, len_w, jm1, jp1;

    otse_ram #(.WIDTH(8), .DEPTH(DOC_CHARS)) u_doc (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    otse_ram #(.WIDTH(HEW), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (r_wptr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    assign e_kind   = h_rdata[HEW-1];
    assign e_pos    = h_rdata[HEW-2 -: LW];
    assign e_client = h_rdata[8:1];
    assign e_drop   = h_rdata[0];
    assign e_pos_w  = PW'(e_pos);

    assign pos_w = PW'(i_item.position);
    assign len_w = PW'(r_len);
    assign jm1   = r_j - PW'(1);
    assign jp1   = r_j + PW'(1);
    assign diff  = r_rev - i_item.base_revision;

    // Start index of the walk: the write pointer stepped back by the missed count.
    always_comb begin
        idx_t = XW'(r_wptr) + XW'(HISTORY_DEPTH) - XW'(diff);
        if (idx_t >= XW'(HISTORY_DEPTH)) begin
            idx_t = idx_t - XW'(HISTORY_DEPTH);
        end
    end

    // Transform of the pending position against one logged entry.
    always_comb begin
        sh_p    = r_p;
        sh_drop = 1'b0;
        if (!e_drop) begin
            if (r_in.edit_kind == KIND_INS && e_kind == KIND_INS) begin
                if (r_p > e_pos_w || (r_p == e_pos_w && r_in.client > e_client)) begin
                    sh_p = r_p + PW'(1);
                end
            end else if (r_in.edit_kind == KIND_DEL && e_kind == KIND_DEL) begin
                if (r_p > e_pos_w) begin
                    sh_p = r_p - PW'(1);
                end else if (r_p == e_pos_w) begin
                    sh_drop = 1'b1;
                end
            end else if (r_in.edit_kind == KIND_INS) begin
                if (r_p > e_pos_w) begin
                    sh_p = r_p - PW'(1);
                end
            end else begin
                if (r_p >= e_pos_w) begin
                    sh_p = r_p + PW'(1);
                end
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_res    = r_res;
        n_p      = r_p;
        n_j      = r_j;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_wptr   = r_wptr;
        n_rev    = r_rev;
        n_len    = r_len;
        n_ovalid = o_valid && !i_ready;
        n_oitem  = o_item;
        d_we     = 1'b0;
        d_waddr  = r_j[AW-1:0];
        d_wdata  = d_rdata;
        d_raddr  = jm1[AW-1:0];
        h_we     = 1'b0;
        h_raddr  = r_idx;
        h_wdata  = {r_in.edit_kind, r_p[LW-1:0], r_in.client, 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in                   = i_item;
                    n_p                    = pos_w;
                    n_res.result_revision  = r_rev;
                    n_res.result_position  = 13'd0;
                    n_res.result_character = 8'd0;
                    n_res.doc_length       = 13'd0;
                    if (i_item.operation == OP_READ) begin
                        n_res.result_kind     = 1'b0;
                        n_res.result_client   = 8'd0;
                        n_res.result_position = i_item.position;
                        d_raddr               = pos_w[AW-1:0];
                        if (pos_w < len_w) begin
                            n_res.status = ST_READ;
                            n_state      = S_DRD;
                        end else begin
                            n_res.status = ST_RANGE;
                            n_state      = S_DONE;
                        end
                    end else begin
                        n_res.result_kind   = i_item.edit_kind;
                        n_res.result_client = i_item.client;
                        if (r_rev == REV_MAX || i_item.base_revision > r_rev ||
                            {1'b0, diff} > (REV_W + 1)'(HISTORY_DEPTH)) begin
                            n_res.status = ST_BADREV;
                            n_state      = S_DONE;
                        end else begin
                            n_cnt   = CW'(diff);
                            n_idx   = idx_t[HAW-1:0];
                            n_state = (diff == '0) ? S_CHK : S_HRD;
                        end
                    end
                end
            end
            S_HRD: begin
                n_state = S_HEV;
            end
            S_HEV: begin
                n_p   = sh_p;
                n_cnt = r_cnt - CW'(1);
                n_idx = (r_idx == HAW'(HISTORY_DEPTH - 1)) ? '0 : r_idx + HAW'(1);
                if (sh_drop) begin
                    // A delete already done elsewhere: log a no-op entry.
                    h_we                  = 1'b1;
                    h_wdata               = {r_in.edit_kind, LW'(0), r_in.client, 1'b1};
                    n_wptr = (r_wptr == HAW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + HAW'(1);
                    n_rev                 = r_rev + REV_W'(1);
                    n_res.status          = ST_DROPPED;
                    n_state               = S_DONE;
                end else begin
                    n_state = (r_cnt == CW'(1)) ? S_CHK : S_HRD;
                end
            end
            S_CHK: begin
                if ((r_in.edit_kind == KIND_INS &&
                     (r_p > len_w || r_len >= LW'(DOC_CHARS))) ||
                    (r_in.edit_kind == KIND_DEL && r_p >= len_w)) begin
                    n_res.status = ST_RANGE;
                    n_state      = S_DONE;
                end else begin
                    h_we                  = 1'b1;
                    n_wptr = (r_wptr == HAW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + HAW'(1);
                    n_rev                 = r_rev + REV_W'(1);
                    n_res.status          = ST_APPLIED;
                    n_res.result_position = r_p[12:0];
                    if (r_in.edit_kind == KIND_INS) begin
                        n_res.result_character = r_in.character;
                        n_j                    = len_w;
                    end else begin
                        n_j = r_p;
                    end
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                // Tail move: read one character for S_MWR, or write the insert here.
                if (r_in.edit_kind == KIND_INS) begin
                    if (r_j == r_p) begin
                        d_we    = 1'b1;
                        d_wdata = r_in.character;
                        n_len   = r_len + LW'(1);
                        n_state = S_DONE;
                    end else begin
                        d_raddr = jm1[AW-1:0];
                        n_state = S_MWR;
                    end
                end else begin
                    if (jp1 >= len_w) begin
                        n_len   = r_len - LW'(1);
                        n_state = S_DONE;
                    end else begin
                        d_raddr = jp1[AW-1:0];
                        n_state = S_MWR;
                    end
                end
            end
            S_MWR: begin
                d_we    = 1'b1;
                n_j     = (r_in.edit_kind == KIND_INS) ? jm1 : jp1;
                n_state = S_MRD;
            end
            S_DRD: begin
                n_res.result_character = d_rdata;
                n_state                = S_DONE;
            end
            S_DONE: begin
                if (!o_valid || i_ready) begin
                    n_oitem            = r_res;
                    n_oitem.doc_length = len_w[12:0];
                    n_ovalid           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rev   <= '0;
            r_len   <= '0;
            r_wptr  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rev   <= n_rev;
            r_len   <= n_len;
            r_wptr  <= n_wptr;
            o_valid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_res  <= n_res;
        r_p    <= n_p;
        r_j    <= n_j;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        o_item <= n_oitem;
    end

    // The document never grows beyond its capacity.
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DOC_CHARS))
        else $error("document length above capacity");

    // The revision advances by at most one per cycle.
    a_rev_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rev == $past(r_rev) || r_rev == $past(r_rev) + REV_W'(1))
        else $error("revision jumped");

    // A fresh result only comes out of the finishing state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid && !i_ready)) |-> $past(r_state == S_DONE))
        else $error("result loaded outside finishing state");

    // The length changes only during the tail move.
    a_len_when: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != $past(r_len)) |-> $past(r_state == S_MRD))
        else $error("length changed outside tail move");

endmodule

FILE: tb/ot_server_edit_engine_checker.sv
// Result checker for the edit engine: watches both channels, predicts and compares.
module ot_server_edit_engine_checker import otse_pkg::*; #(
    parameter int DOC_CHARS     = 4096,
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One logged edit in the predicted history ring.
    typedef struct packed {
        logic        kind;
        logic [12:0] pos;
        logic [7:0]  client;
        logic        dropped;
    } t_log_entry;

    logic [7:0]  doc_bytes [DOC_CHARS];
    t_log_entry  edit_log [HISTORY_DEPTH];
    int unsigned doc_len;
    int unsigned cur_rev;
    t_out_item   expected_results [$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    // Transforms a position against one logged edit; sets drop on a delete collision.
    function automatic int unsigned shift_pos(logic kind, int unsigned p, logic [7:0] client,
                                              t_log_entry e, ref bit drop);
        if (e.dropped) return p;
        if (kind == KIND_INS && e.kind == KIND_INS) begin
            if (p > 32'(e.pos) || (p == 32'(e.pos) && client > e.client)) p++;
        end else if (kind == KIND_DEL && e.kind == KIND_DEL) begin
            if (p > 32'(e.pos)) p--;
            else if (p == 32'(e.pos)) drop = 1'b1;
        end else if (kind == KIND_INS) begin
            if (p > 32'(e.pos)) p--;
        end else begin
            if (p >= 32'(e.pos)) p++;
        end
        return p;
    endfunction

    // Applies one accepted item to the predicted state and returns its result.
    function automatic t_out_item apply_item(t_in_item it);
        t_out_item r;
        bit drop;
        int unsigned p;
        int unsigned idx;
        r = '0;
        r.result_revision = cur_rev[15:0];
        drop = 1'b0;
        if (it.operation == OP_READ) begin
            if (32'(it.position) < doc_len) begin
                r.status = ST_READ;
                r.result_character = doc_bytes[it.position];
            end else begin
                r.status = ST_RANGE;
            end
            r.result_position = it.position;
        end else begin
            r.result_kind   = it.edit_kind;
            r.result_client = it.client;
            if (cur_rev >= 32'(REV_MAX) || 32'(it.base_revision) > cur_rev ||
                    cur_rev - 32'(it.base_revision) > 32'(HISTORY_DEPTH)) begin
                r.status = ST_BADREV;
            end else begin
                p = 32'(it.position);
                for (int unsigned rv = 32'(it.base_revision); rv < cur_rev && !drop; rv++)
                    p = shift_pos(it.edit_kind, p, it.client,
                                  edit_log[rv % HISTORY_DEPTH], drop);
                idx = cur_rev % HISTORY_DEPTH;
                if (drop) begin
                    edit_log[idx] = '{it.edit_kind, 13'd0, it.client, 1'b1};
                    cur_rev++;
                    r.status = ST_DROPPED;
                end else if ((it.edit_kind == KIND_INS &&
                              (p > doc_len || doc_len >= 32'(DOC_CHARS)))
                        || (it.edit_kind == KIND_DEL && p >= doc_len)) begin
                    r.status = ST_RANGE;
                end else begin
                    if (it.edit_kind == KIND_INS) begin
                        for (int unsigned k = doc_len; k > p; k--)
                            doc_bytes[k] = doc_bytes[k-1];
                        doc_bytes[p] = it.character;
                        doc_len++;
                        r.result_character = it.character;
                    end else begin
                        for (int unsigned k = p; k + 1 < doc_len; k++)
                            doc_bytes[k] = doc_bytes[k+1];
                        doc_len--;
                    end
                    edit_log[idx] = '{it.edit_kind, p[12:0], it.client, 1'b0};
                    cur_rev++;
                    r.result_position = p[12:0];
                    r.status = ST_APPLIED;
                end
            end
        end
        r.doc_length = doc_len[12:0];
        return r;
    endfunction

    // Predict on input acceptance, compare on result acceptance.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            doc_len    = 0;
            cur_rev    = 0;
            fail_count <= 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_item(i_in_item));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result item %h", i_out_item);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== i_out_item) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"mismatch: exp st=%0d k=%0d rev=%0d pos=%0d ch=%h",
                                      " cl=%h len=%0d / got st=%0d k=%0d rev=%0d pos=%0d",
                                      " ch=%h cl=%h len=%0d"},
                                exp_r.status, exp_r.result_kind, exp_r.result_revision,
                                exp_r.result_position, exp_r.result_character,
                                exp_r.result_client, exp_r.doc_length,
                                i_out_item.status, i_out_item.result_kind,
                                i_out_item.result_revision, i_out_item.result_position,
                                i_out_item.result_character, i_out_item.result_client,
                                i_out_item.doc_length);
                    end
                end
            end
        end
    end
endmodule

FILE: tb/ot_server_edit_engine_core_tb.sv
// Testbench top for the edit engine: clock, reset, stimulus and verdict.
module ot_server_edit_engine_core_tb;
    import otse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DOC_CHARS     = 4096;
    localparam int HISTORY_DEPTH = 1024;
    localparam int CYCLE_LIMIT   = 8000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_item;
    logic      o_ready;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    bit        idle_free;
    bit        hold_off = 1'b0;
    bit        hold_start = 1'b0;
    int unsigned tb_rev = 0;
    int unsigned tb_len = 0;

    ot_server_edit_engine_core #(.DOC_CHARS(DOC_CHARS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_top (
        .i_clk, .i_rst_n, .i_valid, .i_item, .o_ready, .o_valid, .i_ready, .o_item
    );

    ot_server_edit_engine_checker #(.DOC_CHARS(DOC_CHARS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_chk (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_in_item(i_item),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_item(o_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !hold_off && (idle_free || $urandom_range(99) >= 19);
    end

    // Tracks revision and length roughly from results, to aim random edits.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tb_rev <= 32'(o_item.result_revision) +
                      ((o_item.status == ST_APPLIED || o_item.status == ST_DROPPED) ?
                       32'd1 : 32'd0);
            tb_len <= 32'(o_item.doc_length);
        end
    end

    // Offers one item and waits until it is accepted.
    task automatic send_item(logic op, logic kind, logic [15:0] base, logic [12:0] pos,
                             logic [7:0] ch, logic [7:0] cl);
        while (!idle_free && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= '{op, kind, base, pos, ch, cl};
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Random item, mostly aimed near the current revision and document length: edits or reads.
    task automatic send_random();
        int unsigned back;
        logic [15:0] base;
        logic [12:0] pos;
        int sel;
        sel  = $urandom_range(99);
        back = $urandom_range(6);
        base = (tb_rev > back) ? 16'(tb_rev - back) : 16'd0;
        pos  = 13'($urandom_range(tb_len + 1));
        if (sel < 8) base = 16'($urandom);
        if (sel >= 8 && sel < 12) pos = 13'($urandom);
        if (sel >= 12 && sel < 30)
            send_item(OP_READ, 1'($urandom), 16'($urandom), pos, 8'($urandom),
                      8'($urandom));
        else
            send_item(OP_EDIT, ($urandom_range(99) < 40) ? KIND_DEL : KIND_INS, base, pos,
                      8'($urandom), 8'($urandom));
    endtask

    initial begin
        idle_free = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty document cases, extremes, ties, collisions.
        send_item(OP_READ, KIND_INS, 16'd0, 13'd0, 8'h00, 8'h00);
        send_item(OP_EDIT, KIND_DEL, 16'd0, 13'd0, 8'h00, 8'h00);
        send_item(OP_EDIT, KIND_INS, 16'd1, 13'd0, 8'hFF, 8'hFF);
        send_item(OP_EDIT, KIND_INS, 16'd0, 13'h1FFF, 8'hFF, 8'hFF);
        send_item(OP_EDIT, KIND_INS, 16'd0, 13'd0, 8'hA5, 8'd10);
        send_item(OP_EDIT, KIND_INS, 16'd0, 13'd0, 8'h5A, 8'd20);
        send_item(OP_EDIT, KIND_INS, 16'd0, 13'd0, 8'h3C, 8'd5);
        send_item(OP_EDIT, KIND_INS, 16'd3, 13'd3, 8'hFF, 8'hFF);
        send_item(OP_EDIT, KIND_DEL, 16'd4, 13'd1, 8'h00, 8'd1);
        send_item(OP_EDIT, KIND_DEL, 16'd4, 13'd1, 8'h00, 8'd2);
        send_item(OP_EDIT, KIND_DEL, 16'd4, 13'd1, 8'h00, 8'd3);
        send_item(OP_EDIT, KIND_INS, 16'd5, 13'd2, 8'h11, 8'd0);
        send_item(OP_EDIT, KIND_DEL, 16'd2, 13'd0, 8'h00, 8'd9);
        send_item(OP_EDIT, KIND_INS, 16'hFFFF, 13'd0, 8'h00, 8'd0);
        send_item(OP_READ, KIND_DEL, 16'hFFFF, 13'd0, 8'h00, 8'd0);
        send_item(OP_READ, KIND_INS, 16'd0, 13'd1, 8'h00, 8'd0);
        send_item(OP_READ, KIND_INS, 16'd0, 13'h1FFF, 8'h00, 8'd0);
        drain_results();

        // Random, with a stretch of no idling in the middle.
        for (int n = 0; n < 580; n++) begin
            idle_free = (n >= 200 && n < 280);
            if (n == 350) begin
                drain_results();
                repeat ($urandom_range(20, 5)) @(posedge i_clk);
            end
            if (n == 400) hold_start = 1'b1;
            send_random();
        end
        idle_free = 1'b1;
        drain_results();
        repeat (50) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    initial begin
        wait (hold_start);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end
endmodule

FILE: sim.f
src/otse_pkg.sv
src/otse_ram.sv
src/ot_server_edit_engine_core.sv
tb/ot_server_edit_engine_checker.sv
tb/ot_server_edit_engine_core_tb.sv
